### rtl/core/qrr_pkg.sv
package qrr_pkg;

  localparam int MAX_PROCS = 8;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int ID_W   = 8;
  localparam int PRI_W  = 8;
  localparam int USED_W = 13;
  localparam int REM_W  = 12;
  localparam int Q_W    = 8;
  localparam int KIND_W = 2;

  localparam logic [USED_W-1:0] USED_MAX      = '1;
  localparam logic [Q_W-1:0]    QUANTUM_RESET = 8'd10;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SLICE     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE      = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRI_MODE = 1'd1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [USED_W-1:0] used;
    logic [REM_W-1:0]  rem;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture input item
    logic eval;    // search / read table
    logic commit;  // update table, load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

### rtl/core/qrr_in_if.sv
interface qrr_in_if;
  import qrr_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [PRI_W-1:0] priority_req;
  logic [REM_W-1:0] need_time;

  modport source (output valid, output func, output priority_req, output need_time,
                  input ready);
  modport sink   (input valid, input func, input priority_req, input need_time,
                  output ready);
endinterface

### rtl/core/qrr_out_if.sv
interface qrr_out_if;
  import qrr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   process_id;
  logic [PRI_W-1:0]  served_priority;
  logic [USED_W-1:0] used_time;
  logic [REM_W-1:0]  remaining_time;
  logic              finished;

  modport source (output valid, output kind, output process_id, output served_priority,
                  output used_time, output remaining_time, output finished,
                  input ready);
  modport sink   (input valid, input kind, input process_id, input served_priority,
                  input used_time, input remaining_time, input finished,
                  output ready);
endinterface

### rtl/core/qrr_ctrl.sv
module qrr_ctrl
  import qrr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.latch  = (state_r == ST_IDLE) && in_valid;
  assign cmd.eval   = (state_r == ST_EVAL);
  assign cmd.commit = (state_r == ST_COMMIT) && stat.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = ST_COMMIT;
      ST_COMMIT: if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // an accepted item goes straight from latch to evaluation
  a_latch_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> cmd.eval)
    else $error("accepted item not evaluated");

  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_ready)
    else $error("controller did not return to idle after commit");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.eval, cmd.commit}))
    else $error("overlapping datapath commands");
`endif

endmodule

### rtl/core/qrr_datapath.sv
module qrr_datapath
  import qrr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic                 in_func,
  input  logic [PRI_W-1:0]     in_priority_req,
  input  logic [REM_W-1:0]     in_need_time,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIND_W-1:0]    out_kind,
  output logic [ID_W-1:0]      out_process_id,
  output logic [PRI_W-1:0]     out_served_priority,
  output logic [USED_W-1:0]    out_used_time,
  output logic [REM_W-1:0]     out_remaining_time,
  output logic                 out_finished
);

  // configuration
  logic [Q_W-1:0] quantum_r;
  logic           pri_mode_r;

  // table and control state
  entry_t            tbl_r [MAX_PROCS];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [ID_W-1:0]   next_id_r;

  // captured item and evaluation results
  logic              func_r;
  logic [PRI_W-1:0]  pri_r;
  logic [REM_W-1:0]  need_r;
  logic [IDX_W-1:0]  pos_r;
  entry_t            rd_r;

  // result register
  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r;
  logic [ID_W-1:0]   pid_r;
  logic [PRI_W-1:0]  spri_r;
  logic [USED_W-1:0] used_r;
  logic [REM_W-1:0]  rem_r;
  logic              fin_r;

  logic              full;
  logic              empty;
  logic [IDX_W-1:0]  srch_pos;
  logic              srch_hit;
  logic [IDX_W-1:0]  eval_pos;
  logic              done;
  logic [USED_W:0]   used_sum;
  logic [USED_W-1:0] used_upd;
  logic [CNT_W-1:0]  slice_nxt;

  assign full  = (count_r == CNT_W'(MAX_PROCS));
  assign empty = (count_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  // first entry with lower priority than the new one
  always_comb begin
    srch_pos = '0;
    srch_hit = 1'b0;
    for (int k = MAX_PROCS - 1; k >= 0; k--) begin
      if ((CNT_W'(k) < count_r) && (tbl_r[k].pri < pri_r)) begin
        srch_pos = IDX_W'(k);
        srch_hit = 1'b1;
      end
    end
  end

  // insert position for a load, or the served slot for a tick (stray pointer restarts at 0)
  always_comb begin
    if (func_r == FUNC_LOAD) begin
      eval_pos = (pri_mode_r && srch_hit) ? srch_pos : count_r[IDX_W-1:0];
    end else begin
      eval_pos = (CNT_W'(ptr_r) >= count_r) ? '0 : ptr_r;
    end
  end

  assign done     = ({1'b0, rd_r.rem} <= (REM_W + 1)'(quantum_r));
  assign used_sum = {1'b0, rd_r.used} + (USED_W + 1)'(quantum_r);
  assign used_upd = used_sum[USED_W] ? USED_MAX : used_sum[USED_W-1:0];

  always_comb begin
    count_nxt = done ? count_r - 1'b1 : count_r;
    slice_nxt = done ? CNT_W'(pos_r) : CNT_W'(pos_r) + 1'b1;
    if (slice_nxt >= count_nxt) slice_nxt = '0;
    ptr_nxt = slice_nxt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r  <= QUANTUM_RESET;
      pri_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QUANTUM:  quantum_r  <= cfg_wdata[Q_W-1:0];
        CFG_PRI_MODE: pri_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // item capture and table read
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      pri_r  <= in_priority_req;
      need_r <= in_need_time;
    end
    if (cmd.eval) begin
      pos_r <= eval_pos;
      rd_r  <= tbl_r[eval_pos];
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (cmd.commit && !(func_r == FUNC_LOAD && full) && !(func_r == FUNC_TICK && empty)) begin
      if (func_r == FUNC_LOAD) begin
        for (int k = 0; k < MAX_PROCS; k++) begin
          if (IDX_W'(k) == pos_r) begin
            tbl_r[k] <= '{id: next_id_r, pri: pri_r, used: '0, rem: need_r};
          end else if ((IDX_W'(k) > pos_r) && (CNT_W'(k) <= count_r) && (k > 0)) begin
            tbl_r[k] <= tbl_r[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (done) begin
        for (int k = 0; k < MAX_PROCS - 1; k++) begin
          if ((IDX_W'(k) >= pos_r) && (CNT_W'(k + 1) < count_r)) begin
            tbl_r[k] <= tbl_r[k + 1];
          end
        end
      end else begin
        tbl_r[pos_r].used <= used_upd;
        tbl_r[pos_r].rem  <= rd_r.rem - REM_W'(quantum_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ptr_r     <= '0;
      next_id_r <= '0;
    end else if (cmd.commit) begin
      if (func_r == FUNC_LOAD) begin
        if (!full) begin
          count_r   <= count_r + 1'b1;
          next_id_r <= next_id_r + 1'b1;
          if ((pos_r < ptr_r) && (CNT_W'(ptr_r) < count_r)) ptr_r <= ptr_r + 1'b1;
        end
      end else if (empty) begin
        ptr_r <= '0;
      end else begin
        count_r <= count_nxt;
        ptr_r   <= ptr_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pid_r  <= '0;
      spri_r <= '0;
      used_r <= '0;
      rem_r  <= '0;
      fin_r  <= 1'b0;
      if (func_r == FUNC_LOAD) begin
        kind_r <= full ? KIND_LOAD_FULL : KIND_LOAD_OK;
        if (!full) pid_r <= next_id_r;
      end else if (empty) begin
        kind_r <= KIND_IDLE;
      end else begin
        kind_r <= KIND_SLICE;
        pid_r  <= rd_r.id;
        spri_r <= rd_r.pri;
        used_r <= rd_r.used;
        rem_r  <= rd_r.rem;
        fin_r  <= done;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_process_id      = pid_r;
  assign out_served_priority = spri_r;
  assign out_used_time       = used_r;
  assign out_remaining_time  = rem_r;
  assign out_finished        = fin_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PROCS))
    else $error("entry count above table size");

  a_ptr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r == '0) || (CNT_W'(ptr_r) < count_r))
    else $error("serve pointer outside occupied entries");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without result");
`endif

endmodule

### rtl/core/quantum_round_robin_scheduler.sv
// Round-robin time-slice scheduler over an 8-entry process table. Each input
// transfer is either a load (func 0: add a process with priority_req and
// need_time) or a tick (func 1: run one quantum on the entry under the
// rotating pointer); every input transfer yields exactly one output transfer.
// Each item passes through three steps: capture, table
// search/read (single read of the served slot, parallel priority compare for
// inserts), then commit, where the whole table shifts in a single update for an
// insert or removal and the result register loads. The commit stalls while
// an earlier result still waits on out_ch.ready; a new item is taken as soon
// as the previous one has committed. Configuration (quantum, priority_mode)
// must be written via cfg_we/cfg_idx/cfg_wdata only while no item is in flight;
// the block does not enforce this. Table entries need no clearing pass after reset.
module quantum_round_robin_scheduler
  import qrr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  qrr_in_if.sink               in_ch,
  qrr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cmd_t  cmd;   // sequencer commands
  stat_t stat;  // datapath status

  // sequencer: accept, evaluate, commit
  qrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // process table, pointer, id counter, config and result register
  qrr_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_func             (in_ch.func),
    .in_priority_req     (in_ch.priority_req),
    .in_need_time        (in_ch.need_time),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_kind            (out_ch.kind),
    .out_process_id      (out_ch.process_id),
    .out_served_priority (out_ch.served_priority),
    .out_used_time       (out_ch.used_time),
    .out_remaining_time  (out_ch.remaining_time),
    .out_finished        (out_ch.finished)
  );

endmodule
